// ===== src/gda_pkg.sv =====
package gda_pkg;

   localparam int unsigned MonthsPerYear = 12;
   localparam int unsigned LeapCycle     = 400;
   localparam int unsigned CenturyYears  = 100;
   localparam int unsigned ReduceSteps   = 6;

   localparam logic [4:0] DaysLong     = 5'd31;
   localparam logic [4:0] DaysShort    = 5'd30;
   localparam logic [4:0] DaysFebLeap  = 5'd29;
   localparam logic [4:0] DaysFebPlain = 5'd28;

   localparam logic [3:0] MonthJan = 4'd1;
   localparam logic [3:0] MonthFeb = 4'd2;
   localparam logic [3:0] MonthApr = 4'd4;
   localparam logic [3:0] MonthJun = 4'd6;
   localparam logic [3:0] MonthSep = 4'd9;
   localparam logic [3:0] MonthNov = 4'd11;
   localparam logic [3:0] MonthDec = 4'(MonthsPerYear);

   localparam logic [2:0] ShiftFirst = 3'(ReduceSteps - 1);

   typedef struct packed {
      logic [4:0]  start_day;
      logic [3:0]  start_month;
      logic [13:0] start_year;
      logic [15:0] days_to_add;
   } gda_req_type;

   typedef struct packed {
      logic [4:0]  result_day;
      logic [3:0]  result_month;
      logic [13:0] result_year;
      logic        date_valid;
   } gda_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } gda_state_type;

   typedef struct packed {
      logic load;
      logic reduce;
      logic check;
      logic advance;
      logic publish;
   } gda_ctrl_type;

   typedef struct packed {
      logic reduce_last;
      logic date_ok;
      logic count_zero;
      logic out_free;
   } gda_status_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         unique case (month)
            MonthFeb:                               len = leap ? DaysFebLeap : DaysFebPlain;
            MonthApr, MonthJun, MonthSep, MonthNov: len = DaysShort;
            default:                                len = DaysLong;
         endcase
         return len;
      end
   endfunction

endpackage

// ===== src/gda_sub_unit.sv =====
module gda_sub_unit (
   input  logic [15:0] a,
   input  logic [15:0] b,
   output logic [15:0] diff,
   output logic        ge
);

   logic [16:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign diff = wide[15:0];
   assign ge   = ~wide[16];

endmodule

// ===== src/gda_fsm.sv =====
module gda_fsm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  gda_pkg::gda_status_type status,
   output gda_pkg::gda_ctrl_type   ctrl,
   output logic                    req_ready
);

   gda_pkg::gda_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gda_pkg::ST_IDLE: begin
            if (req_valid) state_in = gda_pkg::ST_REDUCE;
         end
         gda_pkg::ST_REDUCE: begin
            if (status.reduce_last) state_in = gda_pkg::ST_CHECK;
         end
         gda_pkg::ST_CHECK: begin
            state_in = status.date_ok ? gda_pkg::ST_STEP : gda_pkg::ST_FINISH;
         end
         gda_pkg::ST_STEP: begin
            if (status.count_zero) state_in = gda_pkg::ST_FINISH;
         end
         gda_pkg::ST_FINISH: begin
            if (status.out_free) state_in = gda_pkg::ST_IDLE;
         end
         default: state_in = gda_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == gda_pkg::ST_IDLE);
      ctrl.load    = (state_ff == gda_pkg::ST_IDLE) && req_valid;
      ctrl.reduce  = (state_ff == gda_pkg::ST_REDUCE);
      ctrl.check   = (state_ff == gda_pkg::ST_CHECK);
      ctrl.advance = (state_ff == gda_pkg::ST_STEP) && !status.count_zero;
      ctrl.publish = (state_ff == gda_pkg::ST_FINISH) && status.out_free;
   end

endmodule

// ===== src/gregorian_date_add_days.sv =====
// Adds a day count to a Gregorian date. One item is taken at a time; req_ready is high
// only while the block is idle. The year is first reduced modulo 400. Then a single
// shared subtractor advances the date by up to one month per cycle. An invalid start
// date comes back with date_valid low. A finished result sits in an output register
// until taken, and no new item is accepted until the result has moved into that register.
module gregorian_date_add_days (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gda_pkg::gda_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gda_pkg::gda_rsp_type rsp_data
);

   gda_pkg::gda_ctrl_type   ctrl;
   gda_pkg::gda_status_type status;

   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [14:0] year_ff, year_in;
   logic [15:0] count_ff, count_in;
   logic [14:0] r400_ff, r400_in;
   logic [2:0]  shift_ff, shift_in;
   logic        valid_ff, valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   gda_pkg::gda_rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0] op_a, op_b, diff;
   logic        ge;
   logic        leap, date_ok;
   logic [4:0]  len;
   logic [5:0]  rem;
   logic [8:0]  r;

   gda_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl),
      .req_ready (req_ready)
   );

   gda_sub_unit u_sub (
      .a    (op_a),
      .b    (op_b),
      .diff (diff),
      .ge   (ge)
   );

   always_comb begin
      r    = r400_ff[8:0];
      leap = ((year_ff[1:0] == 2'd0) &&
              !(r == 9'd0 || r == 9'(gda_pkg::CenturyYears) ||
                r == 9'(2 * gda_pkg::CenturyYears) || r == 9'(3 * gda_pkg::CenturyYears)))
             || (r == 9'd0);
      len  = gda_pkg::month_len(month_ff, leap);
      rem  = {1'b0, len} - {1'b0, day_ff} + 6'd1;
      date_ok = (month_ff >= gda_pkg::MonthJan) && (month_ff <= gda_pkg::MonthDec) &&
                (year_ff != 15'd0) && (day_ff != 5'd0) && (day_ff <= len);
      if (ctrl.reduce) begin
         op_a = {1'b0, r400_ff};
         op_b = 16'(gda_pkg::LeapCycle) << shift_ff;
      end else begin
         op_a = count_ff;
         op_b = {10'd0, rem};
      end
   end

   always_comb begin
      status.reduce_last = (shift_ff == 3'd0);
      status.date_ok     = date_ok;
      status.count_zero  = (count_ff == 16'd0);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      count_in = count_ff;
      r400_in  = r400_ff;
      shift_in = shift_ff;
      valid_in = valid_ff;
      if (ctrl.load) begin
         day_in   = req_data.start_day;
         month_in = req_data.start_month;
         year_in  = {1'b0, req_data.start_year};
         count_in = req_data.days_to_add;
         r400_in  = {1'b0, req_data.start_year};
         shift_in = gda_pkg::ShiftFirst;
         valid_in = 1'b0;
      end
      if (ctrl.reduce) begin
         if (ge) r400_in = diff[14:0];
         shift_in = shift_ff - 3'd1;
      end
      if (ctrl.check) begin
         valid_in = date_ok;
      end
      if (ctrl.advance) begin
         if (ge) begin
            count_in = diff;
            day_in   = 5'd1;
            if (month_ff == gda_pkg::MonthDec) begin
               month_in = gda_pkg::MonthJan;
               year_in  = year_ff + 15'd1;
               r400_in  = (r400_ff == 15'(gda_pkg::LeapCycle - 1)) ? 15'd0 : r400_ff + 15'd1;
            end else begin
               month_in = month_ff + 4'd1;
            end
         end else begin
            day_in   = day_ff + count_ff[4:0];
            count_in = 16'd0;
         end
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (ctrl.publish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_day   = day_ff;
         rsp_data_in.result_month = month_ff;
         rsp_data_in.result_year  = year_ff[13:0];
         rsp_data_in.date_valid   = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      count_ff    <= count_in;
      r400_ff     <= r400_in;
      shift_ff    <= shift_in;
      valid_ff    <= valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ctrl_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.load, ctrl.reduce, ctrl.check, ctrl.advance, ctrl.publish}))
      else $error("more than one control strobe active");

   a_r400_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |-> r400_ff < 15'(gda_pkg::LeapCycle))
      else $error("year residue out of range while stepping");

   a_day_in_month: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |-> (day_ff != 5'd0 && day_ff <= len))
      else $error("day outside month while stepping");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

// ===== dv/date_add_checker.sv =====
`timescale 1ns / 100ps

module date_add_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  gda_pkg::gda_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  gda_pkg::gda_rsp_type rsp_data,
   output int unsigned          mismatch_count,
   output int unsigned          dates_pending
);

   gda_pkg::gda_rsp_type expected_dates[$];

   function automatic int unsigned month_days(int unsigned month, int unsigned year);
      logic leap;
      leap = ((year % 4 == 0) && (year % gda_pkg::CenturyYears != 0)) ||
             (year % gda_pkg::LeapCycle == 0);
      if (month == gda_pkg::MonthFeb) begin
         return leap ? 32'(gda_pkg::DaysFebLeap) : 32'(gda_pkg::DaysFebPlain);
      end
      if (month == gda_pkg::MonthApr || month == gda_pkg::MonthJun ||
          month == gda_pkg::MonthSep || month == gda_pkg::MonthNov) begin
         return 32'(gda_pkg::DaysShort);
      end
      return 32'(gda_pkg::DaysLong);
   endfunction

   // jumps a month at a time; the year is kept unwrapped until the end
   function automatic gda_pkg::gda_rsp_type advance_date(gda_pkg::gda_req_type item);
      int unsigned day, month, year, count, room;
      gda_pkg::gda_rsp_type date;
      day   = 32'(item.start_day);
      month = 32'(item.start_month);
      year  = 32'(item.start_year);
      count = 32'(item.days_to_add);
      date.date_valid = 1'b0;
      if (month >= gda_pkg::MonthJan && month <= gda_pkg::MonthDec && year != 0 &&
          day >= 1 && day <= month_days(month, year)) begin
         date.date_valid = 1'b1;
         while (count != 0) begin
            room = month_days(month, year) - day;
            if (count <= room) begin
               day   = day + count;
               count = 0;
            end else begin
               count = count - room - 1;
               day   = 1;
               if (month == gda_pkg::MonthDec) begin
                  month = 32'(gda_pkg::MonthJan);
                  year  = year + 1;
               end else begin
                  month = month + 1;
               end
            end
         end
      end
      date.result_day   = 5'(day);
      date.result_month = 4'(month);
      date.result_year  = 14'(year);
      return date;
   endfunction

   function void flag_field(string field, int unsigned want, int unsigned got);
      mismatch_count = mismatch_count + 1;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      gda_pkg::gda_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_dates.push_back(advance_date(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_dates.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               $display("%0t: unexpected item: expected none, actual %p", $time, rsp_data);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_data.result_day !== want.result_day)
                  flag_field("result_day", want.result_day, rsp_data.result_day);
               if (rsp_data.result_month !== want.result_month)
                  flag_field("result_month", want.result_month, rsp_data.result_month);
               if (rsp_data.result_year !== want.result_year)
                  flag_field("result_year", want.result_year, rsp_data.result_year);
               if (rsp_data.date_valid !== want.date_valid)
                  flag_field("date_valid", want.date_valid, rsp_data.date_valid);
            end
         end
      end
      dates_pending <= 32'(expected_dates.size());
   end

endmodule

// ===== dv/tb_gregorian_date_add_days.sv =====
`timescale 1ns / 100ps

module tb_gregorian_date_add_days;

   localparam int unsigned WatchdogLimit = 10000;
   localparam int unsigned PhaseItems    = 83;
   localparam int unsigned HoldOffCycles = 400;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   gda_pkg::gda_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   gda_pkg::gda_rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned dates_pending;
   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 66;
   int unsigned hold_requests = 0;
   int unsigned holds_done    = 0;
   int unsigned quiet_cycles  = 0;

   always #5 clock = ~clock;

   gregorian_date_add_days dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   date_add_checker date_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .dates_pending  (dates_pending)
   );

   function automatic gda_pkg::gda_req_type date_item(int unsigned day, int unsigned month,
                                                      int unsigned year, int unsigned days);
      gda_pkg::gda_req_type item;
      item.start_day   = 5'(day);
      item.start_month = 4'(month);
      item.start_year  = 14'(year);
      item.days_to_add = 16'(days);
      return item;
   endfunction

   // mostly plausible dates; some fully random items for invalid fields
   function automatic gda_pkg::gda_req_type random_item();
      int unsigned pick, day, year, days;
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
         return date_item($urandom(), $urandom(), $urandom(), $urandom());
      end
      day = ($urandom_range(9, 0) < 7) ? $urandom_range(28, 1) : $urandom_range(31, 29);
      pick = $urandom_range(9, 0);
      if (pick < 8) year = $urandom_range(2400, 1);
      else if (pick < 9) year = $urandom_range(9999, 1);
      else year = $urandom_range(16383, 9990);
      pick = $urandom_range(99, 0);
      if (pick < 50) days = $urandom_range(60, 0);
      else if (pick < 85) days = $urandom_range(1500, 0);
      else days = $urandom_range(65535, 0);
      return date_item(day, $urandom_range(32'(gda_pkg::MonthDec), 32'(gda_pkg::MonthJan)),
                       year, days);
   endfunction

   task automatic send_item(input gda_pkg::gda_req_type item);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (dates_pending != 0);
   endtask

   initial begin
      wait (!reset);
      forever begin
         if (hold_requests != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            holds_done = holds_done + 1;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("tb_gregorian_date_add_days: FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(date_item(1, 1, 1, 0));
      send_item(date_item(31, 12, 1999, 1));
      send_item(date_item(28, 2, 2000, 1));
      send_item(date_item(28, 2, 1900, 1));
      send_item(date_item(28, 2, 2024, 1));
      send_item(date_item(29, 2, 2023, 5));
      send_item(date_item(29, 2, 1900, 5));
      send_item(date_item(31, 4, 2021, 5));
      send_item(date_item(0, 5, 2021, 5));
      send_item(date_item(15, 0, 2021, 5));
      send_item(date_item(15, 13, 2021, 5));
      send_item(date_item(31, 15, 16383, 65535));
      send_item(date_item(10, 6, 0, 5));
      send_item(date_item(31, 12, 16383, 1));
      send_item(date_item(31, 12, 16383, 65535));
      send_item(date_item(1, 1, 1, 65535));
      send_item(date_item(31, 1, 9999, 65535));
      send_item(date_item(30, 11, 2023, 31));
      send_item(date_item(0, 0, 0, 0));
      send_item(date_item(29, 2, 2000, 365));
      send_item(date_item(1, 3, 2100, 43690));
      send_item(date_item(31, 12, 10000, 400));
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int unsigned n = 0; n < PhaseItems; n++) begin
            if (phase == 0 && n == 30) hold_requests = hold_requests + 1;
            if (phase == 1 && n == 45) drain_results();
            send_item(random_item());
         end
         drain_results();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && dates_pending == 0) begin
         $display("tb_gregorian_date_add_days: PASS");
      end else begin
         $display("tb_gregorian_date_add_days: FAIL");
      end
      $finish;
   end

endmodule
